/* rtl/core/dpwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dpwc_pkg;

	// Default number of measurement lanes; only the first two have pins.
	localparam int CHANNELS_DEF = 2;

	// The overflow count saturates at this value, and a pulse that saw it is in error.
	localparam logic [1:0] OVF_SATURATE = 2'd2;

	// Reset value of the maximum width register.
	localparam logic [15:0] MAX_WIDTH_RESET = 16'd40000;

	// Item kinds.
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// One incoming request: a timer tick or a pin sample.
	typedef struct packed {
		logic        kind;
		logic [15:0] timer_now;
		logic        pin_ch0;
		logic        pin_ch1;
	} sample_t;

	// One result, delivered for every pin sample.
	typedef struct packed {
		logic [15:0] width_ch0;
		logic [15:0] width_ch1;
		logic        done_ch0;
		logic        done_ch1;
		logic        error_ch0;
		logic        error_ch1;
	} result_t;

	// What one lane reports for the sample it is given.
	typedef struct packed {
		logic [15:0] width;
		logic        done;
		logic        error;
	} lane_res_t;

endpackage

`default_nettype wire

/* rtl/core/dpwc_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module dpwc_lane import dpwc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic        kind,
	input  wire logic [15:0] timer_now,
	input  wire logic        level,
	input  wire logic [15:0] max_width,
	output lane_res_t        res
);

	logic        prev_level_q;
	logic [15:0] edge_time_q;
	logic [1:0]  overflow_count_q;
	logic [15:0] pulse_width_q;
	logic        error_flag_q;

	logic        changed;
	logic        falling;
	logic        ovf_sat;
	logic [15:0] width;
	logic        measured;

	// Edge detection and the width of the pulse that ends here.
	assign changed  = (level != prev_level_q);
	assign falling  = changed && !level;
	assign ovf_sat  = (overflow_count_q >= OVF_SATURATE);
	assign width    = timer_now - edge_time_q;
	assign measured = falling && !ovf_sat;

	// Values after this sample, as reported in the result.
	always_comb begin
		res.width = measured ? width : pulse_width_q;
		res.done  = measured;
		res.error = error_flag_q || (falling && (ovf_sat || (width > max_width)));
	end

	// Channel state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q     <= 1'b0;
			edge_time_q      <= '0;
			overflow_count_q <= '0;
			pulse_width_q    <= '0;
			error_flag_q     <= 1'b0;
		end else if (take) begin
			if (kind == KIND_TICK) begin
				if (!ovf_sat) begin
					overflow_count_q <= overflow_count_q + 2'd1;
				end
			end else if (changed) begin
				prev_level_q     <= level;
				overflow_count_q <= '0;
				edge_time_q      <= timer_now;
				pulse_width_q    <= res.width;
				error_flag_q     <= res.error;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dpwc_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module dpwc_merge import dpwc_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      take,
	input  wire logic      kind,
	input  wire lane_res_t lane_res [CHANNELS],
	output logic           advance,
	output logic           result_valid,
	input  wire logic      result_stall,
	output result_t        result
);

	result_t merged;

	// The output register moves on when it is empty or being taken.
	assign advance = !result_valid || !result_stall;

	// Gather the reporting lanes into one result; a missing second lane reads as zero.
	always_comb begin
		merged           = '0;
		merged.width_ch0 = lane_res[0].width;
		merged.done_ch0  = lane_res[0].done;
		merged.error_ch0 = lane_res[0].error;
		if (CHANNELS > 1) begin
			merged.width_ch1 = lane_res[CHANNELS > 1 ? 1 : 0].width;
			merged.done_ch1  = lane_res[CHANNELS > 1 ? 1 : 0].done;
			merged.error_ch1 = lane_res[CHANNELS > 1 ? 1 : 0].error;
		end
	end

	// Output register: a pin sample loads a result, a tick leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= take && (kind == KIND_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take) begin
			result <= merged;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dual_pulse_width_capture_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// High-pulse width meter for two pins against a free-running 16-bit timer. Each request is
// either a timer overflow tick or a pin sample; every pin sample yields one result with the
// last widths, per-channel done flags and sticky error flags, and a tick yields none. The
// block takes one request per clock cycle and the result appears in the output register in
// the next cycle; each channel lane does one subtraction and one compare combinationally, so
// the output register is the only register between request and result. A request is held off
// only while a result waits in the output register and is stalled. The max_width register is
// written through cfg_we and cfg_wdata and resets to 40000. Lanes beyond the second have no
// pin and stay idle.
module dual_pulse_width_capture_core import dpwc_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire sample_t     sample,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0] max_width_reg_q;
	logic        advance;
	logic        take;
	lane_res_t   lane_res [CHANNELS];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_reg_q <= MAX_WIDTH_RESET;
		end else if (cfg_we) begin
			max_width_reg_q <= cfg_wdata;
		end
	end

	assign sample_stall = !advance;
	assign take         = sample_valid && advance;

	// One lane per channel.
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic level;
		if (c == 0) begin : g_pin0
			assign level = sample.pin_ch0;
		end else if (c == 1) begin : g_pin1
			assign level = sample.pin_ch1;
		end else begin : g_nopin
			assign level = 1'b0;
		end

		dpwc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.take      (take),
			.kind      (sample.kind),
			.timer_now (sample.timer_now),
			.level     (level),
			.max_width (max_width_reg_q),
			.res       (lane_res[c])
		);
	end

	// Merge the lanes into the registered result.
	dpwc_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.kind         (sample.kind),
		.lane_res     (lane_res),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	// An accepted pin sample always shows a result in the next cycle.
	a_sample_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall && sample.kind == KIND_SAMPLE) |=> result_valid)
		else $error("pin sample did not produce a result");

	// A tick into an empty output stage leaves it empty.
	a_tick_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall && sample.kind == KIND_TICK && !result_valid)
		|=> !result_valid)
		else $error("tick produced a result");

	// No request is taken while a stalled result would be overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> sample_stall)
		else $error("request accepted over a stalled result");

	// A configuration write always lands in the register.
	a_cfg_written: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (max_width_reg_q == $past(cfg_wdata)))
		else $error("configuration write lost");
`endif

endmodule

`default_nettype wire
